### rtl/dsa_pkg.sv
package dsa_pkg;

   // Field widths
   localparam int INDEX_W     = 10;
   localparam int CAP_W       = 11;
   localparam int ADDR64_W    = 64;
   localparam int STRIDE_W    = 13;
   localparam int CODE_W      = 2;
   localparam int OFFSET_W    = INDEX_W + STRIDE_W;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   // Request modes
   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   // Result status codes
   localparam logic [CODE_W-1:0] ST_OK        = 2'd0;
   localparam logic [CODE_W-1:0] ST_FULL      = 2'd1;
   localparam logic [CODE_W-1:0] ST_RANGE     = 2'd2;
   localparam logic [CODE_W-1:0] ST_NONE_LIVE = 2'd3;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_CAPACITY       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CPU_BASE       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_GPU_BASE       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SLOT_STRIDE    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SHADER_VISIBLE = 3'd4;

   // Configuration reset values
   localparam logic [CAP_W-1:0]    CAPACITY_RESET = 11'd1024;
   localparam logic [STRIDE_W-1:0] STRIDE_RESET   = 13'd32;

   // Request payload
   typedef struct packed {
      logic               mode;
      logic [INDEX_W-1:0] free_index;
   } req_type;

   // Result payload
   typedef struct packed {
      logic [INDEX_W-1:0]  slot_index;
      logic [ADDR64_W-1:0] cpu_address;
      logic [ADDR64_W-1:0] gpu_address;
      logic [CODE_W-1:0]   status;
      logic [CAP_W-1:0]    live_slots;
   } rsp_type;

   // Controller state
   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_READ,
      S_MULTIPLY,
      S_LOAD
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;
      logic decide;
      logic take_pop;
      logic multiply;
      logic load;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_pop;
      logic out_ready;
   } dp_status_type;

endpackage

### rtl/dsa_ctrl.sv
module dsa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  dsa_pkg::dp_status_type dp_status,
   output dsa_pkg::dp_cmd_type    dp_cmd
);

   dsa_pkg::state_type state_ff;
   dsa_pkg::state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dsa_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Requests are taken only between items
   assign req_stall = (state_ff != dsa_pkg::S_IDLE);

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      unique case (state_ff)
         dsa_pkg::S_IDLE: begin
            if (req_valid) begin
               dp_cmd.capture = 1'b1;
               state_in       = dsa_pkg::S_DECIDE;
            end
         end
         dsa_pkg::S_DECIDE: begin
            dp_cmd.decide = 1'b1;
            state_in      = dp_status.is_pop ? dsa_pkg::S_READ : dsa_pkg::S_MULTIPLY;
         end
         dsa_pkg::S_READ: begin
            dp_cmd.take_pop = 1'b1;
            state_in        = dsa_pkg::S_MULTIPLY;
         end
         dsa_pkg::S_MULTIPLY: begin
            dp_cmd.multiply = 1'b1;
            state_in        = dsa_pkg::S_LOAD;
         end
         dsa_pkg::S_LOAD: begin
            if (dp_status.out_ready) begin
               dp_cmd.load = 1'b1;
               state_in    = dsa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = dsa_pkg::S_IDLE;
         end
      endcase
   end

endmodule

### rtl/dsa_datapath.sv
module dsa_datapath #(
   parameter int MAX_SLOTS = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dsa_pkg::req_type                     req_data,
   input  dsa_pkg::dp_cmd_type                  dp_cmd,
   output dsa_pkg::dp_status_type               dp_status,
   input  logic                                 csr_write_enable,
   input  logic [dsa_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [dsa_pkg::CSR_DATA_W-1:0]       csr_write_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output dsa_pkg::rsp_type                     rsp_data
);

   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
   localparam int ADDR_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CMP_W  = (CNT_W > dsa_pkg::CAP_W) ? CNT_W : dsa_pkg::CAP_W;
   localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_SLOTS);

   // Configuration registers
   logic [dsa_pkg::CAP_W-1:0]    capacity_ff;
   logic [dsa_pkg::ADDR64_W-1:0] cpu_base_ff;
   logic [dsa_pkg::ADDR64_W-1:0] gpu_base_ff;
   logic [dsa_pkg::STRIDE_W-1:0] stride_ff;
   logic                         visible_ff;

   // Allocator state
   logic [CNT_W-1:0] free_depth_ff;
   logic [CNT_W-1:0] next_fresh_ff;
   logic [CNT_W-1:0] live_count_ff;
   logic [dsa_pkg::INDEX_W-1:0] free_stack [MAX_SLOTS];

   // Item registers
   dsa_pkg::req_type               req_ff;
   logic [dsa_pkg::INDEX_W-1:0]    slot_ff;
   logic [dsa_pkg::CODE_W-1:0]     code_ff;
   logic [dsa_pkg::INDEX_W-1:0]    rd_data_ff;
   logic [dsa_pkg::OFFSET_W-1:0]   offset_ff;
   logic                           rsp_valid_ff;
   dsa_pkg::rsp_type               rsp_data_ff;

   // Decision signals
   logic [CMP_W-1:0]            cap_cmp;
   logic [CMP_W-1:0]            cap_eff;
   logic [CMP_W-1:0]            depth_cmp;
   logic [CMP_W-1:0]            fresh_cmp;
   logic [CMP_W-1:0]            fidx_cmp;
   logic [CNT_W-1:0]            depth_m1;
   logic [ADDR_W-1:0]           wr_addr;
   logic [ADDR_W-1:0]           rd_addr;
   logic [dsa_pkg::INDEX_W-1:0] slot_in;
   logic [dsa_pkg::CODE_W-1:0]  code_in;
   logic                        do_pop;
   logic                        do_fresh;
   logic                        do_push;
   logic                        addr_ok;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= dsa_pkg::CAPACITY_RESET;
         cpu_base_ff <= '0;
         gpu_base_ff <= '0;
         stride_ff   <= dsa_pkg::STRIDE_RESET;
         visible_ff  <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            dsa_pkg::REG_CAPACITY:       capacity_ff <= csr_write_data[dsa_pkg::CAP_W-1:0];
            dsa_pkg::REG_CPU_BASE:       cpu_base_ff <= csr_write_data;
            dsa_pkg::REG_GPU_BASE:       gpu_base_ff <= csr_write_data;
            dsa_pkg::REG_SLOT_STRIDE:    stride_ff   <= csr_write_data[dsa_pkg::STRIDE_W-1:0];
            dsa_pkg::REG_SHADER_VISIBLE: visible_ff  <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   // Operands widened to a common compare width; capacity clamps at the stack depth
   assign cap_cmp   = CMP_W'(capacity_ff);
   assign cap_eff   = (cap_cmp > MAX_CMP) ? MAX_CMP : cap_cmp;
   assign depth_cmp = CMP_W'(free_depth_ff);
   assign fresh_cmp = CMP_W'(next_fresh_ff);
   assign fidx_cmp  = CMP_W'(req_ff.free_index);
   assign depth_m1  = free_depth_ff - 1'b1;
   assign wr_addr   = free_depth_ff[ADDR_W-1:0];
   assign rd_addr   = depth_m1[ADDR_W-1:0];

   // Allocate / free decision; an erroring item leaves all state alone
   always_comb begin
      slot_in  = '0;
      code_in  = dsa_pkg::ST_OK;
      do_pop   = 1'b0;
      do_fresh = 1'b0;
      do_push  = 1'b0;
      if (req_ff.mode == dsa_pkg::MODE_ALLOC) begin
         priority if (free_depth_ff != '0) begin
            do_pop = 1'b1;
         end else if (fresh_cmp < cap_eff) begin
            do_fresh = 1'b1;
            slot_in  = dsa_pkg::INDEX_W'(next_fresh_ff);
         end else begin
            code_in = dsa_pkg::ST_FULL;
         end
      end else begin
         slot_in = req_ff.free_index;
         priority if (fidx_cmp >= cap_eff) begin
            code_in = dsa_pkg::ST_RANGE;
         end else if (live_count_ff == '0 || depth_cmp >= MAX_CMP) begin
            code_in = dsa_pkg::ST_NONE_LIVE;
         end else begin
            do_push = 1'b1;
         end
      end
   end

   // Counters
   always_ff @(posedge clock) begin
      if (reset) begin
         free_depth_ff <= '0;
         next_fresh_ff <= '0;
         live_count_ff <= '0;
      end else if (dp_cmd.decide) begin
         if (do_pop) begin
            free_depth_ff <= depth_m1;
            live_count_ff <= live_count_ff + 1'b1;
         end
         if (do_fresh) begin
            next_fresh_ff <= next_fresh_ff + 1'b1;
            live_count_ff <= live_count_ff + 1'b1;
         end
         if (do_push) begin
            free_depth_ff <= free_depth_ff + 1'b1;
            live_count_ff <= live_count_ff - 1'b1;
         end
      end
   end

   // Free stack memory: push write, registered pop read
   always_ff @(posedge clock) begin
      if (dp_cmd.decide && do_push) begin
         free_stack[wr_addr] <= req_ff.free_index;
      end
      if (dp_cmd.decide && do_pop) begin
         rd_data_ff <= free_stack[rd_addr];
      end
   end

   // Item payload registers
   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         req_ff <= req_data;
      end
      if (dp_cmd.decide) begin
         slot_ff <= slot_in;
         code_ff <= code_in;
      end else if (dp_cmd.take_pop) begin
         slot_ff <= rd_data_ff;
      end
      if (dp_cmd.multiply) begin
         offset_ff <= dsa_pkg::OFFSET_W'(slot_ff) * dsa_pkg::OFFSET_W'(stride_ff);
      end
   end

   // Addresses only for a successful allocate
   assign addr_ok = (code_ff == dsa_pkg::ST_OK) && (req_ff.mode == dsa_pkg::MODE_ALLOC);

   // Output register
   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         rsp_data_ff.slot_index  <= slot_ff;
         rsp_data_ff.status      <= code_ff;
         rsp_data_ff.live_slots  <= dsa_pkg::CAP_W'(live_count_ff);
         rsp_data_ff.cpu_address <= addr_ok ?
            cpu_base_ff + dsa_pkg::ADDR64_W'(offset_ff) : '0;
         rsp_data_ff.gpu_address <= (addr_ok && visible_ff) ?
            gpu_base_ff + dsa_pkg::ADDR64_W'(offset_ff) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dp_cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data            = rsp_data_ff;
   assign dp_status.is_pop    = do_pop;
   assign dp_status.out_ready = !rsp_valid_ff || !rsp_stall;

endmodule

### rtl/descriptor_slot_allocator_top.sv
// Slot allocator for a fixed descriptor heap.
// Request channel (req_valid / req_stall / req_data): mode 0 allocates a slot,
// mode 1 returns req_data.free_index. Allocation reuses the most recently
// returned index first, otherwise the next never-used index below capacity.
// Result channel (rsp_valid / rsp_stall / rsp_data): one transfer per request
// with the slot index, CPU and GPU addresses (base + index * stride on a good
// allocate, else zero; GPU also needs visible), status code, live count after.
// Configuration (csr_write_enable / csr_index / csr_write_data) must be
// written only while no request is in flight (the block does not enforce it);
// there is no read-back. A request is captured in idle and then passes
// through decide, a read state when the slot is reused from the free stack
// (for the registered stack read), multiply and load, where it waits until
// the output register is free. The controller handles one request at a time
// and is back in idle right after loading the output register.
// A stalled result holds in the output register; the next request is still
// taken and worked on, and it waits only to be loaded into that register.
// Reset clears the counters and restores register defaults; the free stack
// needs no clearing pass.
module descriptor_slot_allocator_top #(
   parameter int MAX_SLOTS = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  dsa_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output dsa_pkg::rsp_type                rsp_data,
   input  logic                            csr_write_enable,
   input  logic [dsa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dsa_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   dsa_pkg::dp_cmd_type    dp_cmd;
   dsa_pkg::dp_status_type dp_status;

   // Sequencer
   dsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   // Stack, counters, address arithmetic and output register
   dsa_datapath #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_data),
      .dp_cmd           (dp_cmd),
      .dp_status        (dp_status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data)
   );

endmodule
